/* sv/mpscan_pkg.sv */
// ----------------------------------------------------------------------------
// Multipath option scanner package
// Shared widths, limits, parse phases and stop codes of the option scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mpscan_pkg;

	localparam int AREA_W = 6;
	localparam logic [AREA_W-1:0] MAX_OPTION_BYTES = AREA_W'(40);

	localparam logic [7:0] KIND_END_OF_LIST = 8'd0;
	localparam logic [7:0] KIND_NO_OP       = 8'd1;
	localparam logic [7:0] MIN_OPT_LEN      = 8'd2;

	typedef enum logic [1:0] {
		PH_KIND = 2'd0,
		PH_LEN  = 2'd1,
		PH_BODY = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_AREA_END = 2'd0,
		ST_EOL      = 2'd1,
		ST_SHORT    = 2'd2,
		ST_OVERRUN  = 2'd3
	} status_t;

	typedef enum logic {
		CFG_WANTED_SUBTYPE = 1'b0,
		CFG_MULTIPATH_KIND = 1'b1
	} cfg_idx_t;

endpackage

`default_nettype wire

/* sv/tcp_option_mptcp_scanner_unit.sv */
// ----------------------------------------------------------------------------
// TCP option multipath scanner
// Walks a TCP option area byte by byte and reports the first multipath
// option and the first one carrying the configured subtype.
// ----------------------------------------------------------------------------
// The block takes one option byte per cycle and gives one result word per
// option area, after the word that carries the area's last byte (or at once
// for an empty area). An accepted word lands in an input register, is decoded
// against the scan state in one pass of short logic, and any result goes to
// an output register, taking the result as the word with the last byte
// leaves the input register. Input words keep flowing while a result
// waits to be taken; only a second result behind an untaken one stalls the
// input. Configuration comes through its own channel, which is always ready.
`default_nettype none

module tcp_option_mptcp_scanner_unit
	import mpscan_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        opt_byte,
	input  wire logic              area_start,
	input  wire logic [AREA_W-1:0] area_len,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [1:0]             status,
	output logic                   first_found,
	output logic [AREA_W-1:0]      first_offset,
	output logic [AREA_W-1:0]      first_length,
	output logic [3:0]             first_subtype,
	output logic                   wanted_found,
	output logic [AREA_W-1:0]      wanted_offset,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              cfg_index,
	input  wire logic [7:0]        cfg_data
);

	logic [3:0] wanted_subtype_q;
	logic [7:0] multipath_kind_q;

	logic              valid_s1;
	logic [7:0]        byte_s1;
	logic              start_s1;
	logic [AREA_W-1:0] len_s1;

	logic [AREA_W-1:0] pos_q, total_q, skip_q, coff_q, clen_q;
	phase_t            phase_q;
	logic              ismp_q, stopped_q, f_found_q, w_found_q;
	status_t           stop_st_q;
	logic [AREA_W-1:0] f_off_q, f_len_q, w_off_q;
	logic [3:0]        f_sub_q;

	logic [AREA_W-1:0] pos_n, total_n, skip_n, coff_n, clen_n;
	phase_t            phase_n;
	logic              ismp_n, stopped_n, f_found_n, w_found_n;
	status_t           stop_st_n;
	logic [AREA_W-1:0] f_off_n, f_len_n, w_off_n;
	logic [3:0]        f_sub_n;

	logic              emit;
	status_t           emit_st;
	logic              r_f_found, r_w_found;
	logic [AREA_W-1:0] r_f_off, r_f_len, r_w_off;
	logic [3:0]        r_f_sub;
	logic [AREA_W-1:0] room;
	logic [AREA_W-1:0] pos_inc;
	logic              active;
	logic              out_free, advance;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wanted_subtype_q <= '0;
			multipath_kind_q <= 8'd30;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_WANTED_SUBTYPE: wanted_subtype_q <= cfg_data[3:0];
				CFG_MULTIPATH_KIND: multipath_kind_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		pos_n     = pos_q;
		total_n   = total_q;
		phase_n   = phase_q;
		skip_n    = skip_q;
		ismp_n    = ismp_q;
		coff_n    = coff_q;
		clen_n    = clen_q;
		stopped_n = stopped_q;
		stop_st_n = stop_st_q;
		f_found_n = f_found_q;
		f_off_n   = f_off_q;
		f_len_n   = f_len_q;
		f_sub_n   = f_sub_q;
		w_found_n = w_found_q;
		w_off_n   = w_off_q;
		emit      = 1'b0;
		emit_st   = ST_AREA_END;
		room      = '0;
		pos_inc   = '0;
		if (start_s1) begin
			pos_n     = '0;
			total_n   = (len_s1 > MAX_OPTION_BYTES) ? MAX_OPTION_BYTES : len_s1;
			phase_n   = PH_KIND;
			skip_n    = '0;
			ismp_n    = 1'b0;
			coff_n    = '0;
			clen_n    = '0;
			stopped_n = 1'b0;
			stop_st_n = ST_AREA_END;
			f_found_n = 1'b0;
			f_off_n   = '0;
			f_len_n   = '0;
			f_sub_n   = '0;
			w_found_n = 1'b0;
			w_off_n   = '0;
		end
		active = (total_n != '0);
		if (start_s1 && !active) begin
			emit = 1'b1;
		end else if (active) begin
			if (!stopped_n) begin
				case (phase_n)
					PH_KIND: begin
						if (byte_s1 == KIND_END_OF_LIST) begin
							stopped_n = 1'b1;
							stop_st_n = ST_EOL;
						end else if (byte_s1 != KIND_NO_OP) begin
							coff_n  = pos_n;
							ismp_n  = (byte_s1 == multipath_kind_q);
							phase_n = PH_LEN;
						end
					end
					PH_LEN: begin
						room = total_n - coff_n;
						if (byte_s1 < MIN_OPT_LEN) begin
							stopped_n = 1'b1;
							stop_st_n = ST_SHORT;
						end else if (byte_s1 > {2'b00, room}) begin
							stopped_n = 1'b1;
							stop_st_n = ST_OVERRUN;
						end else begin
							clen_n = byte_s1[AREA_W-1:0];
							if (byte_s1 == MIN_OPT_LEN) begin
								if (ismp_n && !f_found_n) begin
									f_found_n = 1'b1;
									f_off_n   = coff_n;
									f_len_n   = byte_s1[AREA_W-1:0];
									f_sub_n   = '0;
								end
								phase_n = PH_KIND;
							end else begin
								skip_n  = byte_s1[AREA_W-1:0] - AREA_W'(2);
								phase_n = PH_BODY;
							end
						end
					end
					default: begin
						if (ismp_n && (skip_n == clen_n - AREA_W'(2))) begin
							if (!f_found_n) begin
								f_found_n = 1'b1;
								f_off_n   = coff_n;
								f_len_n   = clen_n;
								f_sub_n   = byte_s1[7:4];
							end
							if ((byte_s1[7:4] == wanted_subtype_q) && !w_found_n) begin
								w_found_n = 1'b1;
								w_off_n   = coff_n;
							end
						end
						if (skip_n != '0) begin
							skip_n = skip_n - AREA_W'(1);
						end
						if (skip_n == '0) begin
							phase_n = PH_KIND;
						end
					end
				endcase
			end
			pos_inc = pos_n + AREA_W'(1);
			pos_n   = pos_inc;
			if (pos_inc >= total_n) begin
				emit = 1'b1;
				if (stopped_n) begin
					emit_st = stop_st_n;
				end else if (phase_n == PH_LEN) begin
					emit_st = ST_OVERRUN;
				end else begin
					emit_st = ST_AREA_END;
				end
			end
		end
		r_f_found = f_found_n;
		r_f_off   = f_off_n;
		r_f_len   = f_len_n;
		r_f_sub   = f_sub_n;
		r_w_found = w_found_n;
		r_w_off   = w_off_n;
		if (emit) begin
			pos_n     = '0;
			total_n   = '0;
			phase_n   = PH_KIND;
			skip_n    = '0;
			ismp_n    = 1'b0;
			coff_n    = '0;
			clen_n    = '0;
			stopped_n = 1'b0;
			stop_st_n = ST_AREA_END;
			f_found_n = 1'b0;
			f_off_n   = '0;
			f_len_n   = '0;
			f_sub_n   = '0;
			w_found_n = 1'b0;
			w_off_n   = '0;
		end
	end

	assign out_free = !out_valid || out_ready;
	assign advance  = valid_s1 && (out_free || !emit);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= opt_byte;
			start_s1 <= area_start;
			len_s1   <= area_len;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			total_q   <= '0;
			phase_q   <= PH_KIND;
			skip_q    <= '0;
			ismp_q    <= 1'b0;
			coff_q    <= '0;
			clen_q    <= '0;
			stopped_q <= 1'b0;
			stop_st_q <= ST_AREA_END;
			f_found_q <= 1'b0;
			f_off_q   <= '0;
			f_len_q   <= '0;
			f_sub_q   <= '0;
			w_found_q <= 1'b0;
			w_off_q   <= '0;
		end else if (advance) begin
			pos_q     <= pos_n;
			total_q   <= total_n;
			phase_q   <= phase_n;
			skip_q    <= skip_n;
			ismp_q    <= ismp_n;
			coff_q    <= coff_n;
			clen_q    <= clen_n;
			stopped_q <= stopped_n;
			stop_st_q <= stop_st_n;
			f_found_q <= f_found_n;
			f_off_q   <= f_off_n;
			f_len_q   <= f_len_n;
			f_sub_q   <= f_sub_n;
			w_found_q <= w_found_n;
			w_off_q   <= w_off_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			status        <= emit_st;
			first_found   <= r_f_found;
			first_offset  <= r_f_off;
			first_length  <= r_f_len;
			first_subtype <= r_f_sub;
			wanted_found  <= r_w_found;
			wanted_offset <= r_w_off;
		end
	end

endmodule

`default_nettype wire

/* sv/mpscan_checker.sv */
// ----------------------------------------------------------------------------
// Multipath option scanner checker
// Port-level properties of the scanner's result words, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module mpscan_checker
	import mpscan_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire logic [1:0]        status,
	input wire logic              first_found,
	input wire logic [AREA_W-1:0] first_offset,
	input wire logic [AREA_W-1:0] first_length,
	input wire logic [3:0]        first_subtype,
	input wire logic              wanted_found,
	input wire logic [AREA_W-1:0] wanted_offset
);

	// A stalled result word keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) &&
		$stable(first_offset) && $stable(wanted_offset))
		else $error("result word changed while stalled");

	// Without a multipath option the first record reads as zero.
	a_first_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !first_found |-> first_offset == '0 &&
		first_length == '0 && first_subtype == '0)
		else $error("first record not zero while not found");

	// A wanted match is always a multipath option, so the first record exists.
	a_wanted_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && wanted_found |-> first_found &&
		wanted_offset >= first_offset && first_length >= AREA_W'(2))
		else $error("wanted record without a consistent first record");

	// Without a wanted match its offset reads as zero.
	a_wanted_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !wanted_found |-> wanted_offset == '0)
		else $error("wanted offset not zero while not found");

endmodule

bind tcp_option_mptcp_scanner_unit mpscan_checker u_mpscan_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.status        (status),
	.first_found   (first_found),
	.first_offset  (first_offset),
	.first_length  (first_length),
	.first_subtype (first_subtype),
	.wanted_found  (wanted_found),
	.wanted_offset (wanted_offset)
);

`default_nettype wire
